// ===== rtl/prq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prq_pkg
// shared constants for the priority ready queue scheduler
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int DEF_MAX_THREADS   = 16;
    localparam int DEF_PRIORITY_BITS = 8;

    localparam int OPCODE_W = 3;
    localparam int TID_W    = 4;
    localparam int BPRIO_W  = 8;

    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_WAIT    = 3'd3;
    localparam logic [2:0] OP_WAKE_UP = 3'd4;
    localparam logic [2:0] OP_SUSPEND = 3'd5;
    localparam logic [2:0] OP_RESUME  = 3'd6;
    localparam logic [2:0] OP_YIELD   = 3'd7;

    localparam logic [1:0] RS_STOPPED  = 2'd0;
    localparam logic [1:0] RS_RUNNABLE = 2'd1;
    localparam logic [1:0] RS_WAITING  = 2'd2;

endpackage : prq_pkg
`default_nettype wire

// ===== rtl/priority_ready_queue_thread_states.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// priority_ready_queue_thread_states
// hardware thread scheduler with a priority-sorted ready queue
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one command beat (opcode, thread_id, create priority).
//   m_ channel returns one result beat per command: status, head_valid,
//   head_thread and schedule_changed.
//   thread state (priority, run state, suspended flag) lives in per-thread
//   flop arrays; the ready queue order lives in a synchronous memory with a
//   registered read port, walked one entry per cycle with one read and one
//   write, never to the same entry in the same cycle.
//   a command that leaves the queue alone goes straight to the head read; a
//   removal walks the queue and closes the gap, an insert scans for its slot,
//   opens a gap from the tail and sets the entry; yield does removal then insert.
//   one command is processed at a time; s_ready is high only while idle, so
//   the next command can be accepted in the cycle after a result is registered.
//   a stalled receiver holds the result in the output register; the next
//   command still runs and waits at its last step until the register frees.
//   reset clears all run states, flags, priorities and the queue count;
//   the order memory needs no clearing since only entries below the count
//   are ever used.
// ----------------------------------------------------------------------------
module priority_ready_queue_thread_states #(
    parameter int MAX_THREADS   = prq_pkg::DEF_MAX_THREADS,
    parameter int PRIORITY_BITS = prq_pkg::DEF_PRIORITY_BITS
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [prq_pkg::OPCODE_W-1:0]      s_opcode,
    input  wire  [prq_pkg::TID_W-1:0]         s_thread_id,
    input  wire  [prq_pkg::BPRIO_W-1:0]       s_create_prio,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic                              m_status,
    output logic                              m_head_valid,
    output logic [prq_pkg::TID_W-1:0]         m_head_thread,
    output logic                              m_schedule_changed
);
    import prq_pkg::*;

    localparam int IW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RFIND  = 3'd1; // scan for removal target
    localparam logic [2:0] ST_RSHIFT = 3'd2; // close the gap
    localparam logic [2:0] ST_IFIND  = 3'd3; // scan for insert position
    localparam logic [2:0] ST_ISHIFT = 3'd4; // open a gap from the tail
    localparam logic [2:0] ST_ISET   = 3'd5; // drop the thread into the gap
    localparam logic [2:0] ST_HEAD   = 3'd6; // read entry 0
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]               state_reg, state_next;
    logic [PRIORITY_BITS-1:0] prio_reg  [MAX_THREADS];
    logic [1:0]               rs_reg    [MAX_THREADS];
    logic                     susp_reg  [MAX_THREADS];
    logic [CW-1:0]            count_reg;
    logic [IW-1:0]            tid_reg;
    logic                     do_ins_reg;   // insert after removal walk
    logic                     chg_reg;
    logic                     err_reg;
    logic [CW-1:0]            pos_reg;      // walk index
    logic [CW-1:0]            sh_reg;       // tail shift destination

    // order memory
    logic [IW-1:0] order_mem [MAX_THREADS];
    logic [IW-1:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          rd_en;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] wr_data;
    logic          wr_en;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            order_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= order_mem[rd_addr];
        end
    end

    logic          out_valid_reg;
    logic          out_status_reg;
    logic          out_hv_reg;
    logic [IW-1:0] out_head_reg;
    logic          out_chg_reg;

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = out_valid_reg;
    assign m_status           = out_status_reg;
    assign m_head_valid       = out_hv_reg;
    assign m_head_thread      = TID_W'(out_head_reg);
    assign m_schedule_changed = out_chg_reg;

    wire            accept   = s_valid && s_ready;
    wire            out_free = !out_valid_reg || m_ready;
    wire            tid_ok   = 32'(s_thread_id) < MAX_THREADS;
    wire [IW-1:0]   s_tid    = IW'(s_thread_id);
    wire [IW-1:0]   pos_ix   = pos_reg[IW-1:0];

    // command decode
    logic       c_err, c_rem, c_ins;
    logic [1:0] c_rs;
    logic       c_susp;
    always_comb begin
        c_err  = 1'b0;
        c_rem  = 1'b0;
        c_ins  = 1'b0;
        c_rs   = rs_reg[s_tid];
        c_susp = susp_reg[s_tid];
        if (!tid_ok) begin
            c_err = 1'b1;
        end else begin
            unique case (s_opcode)
                OP_CREATE: begin
                    c_err  = c_rs != RS_STOPPED;
                    c_susp = 1'b0;
                end
                OP_START: begin
                    c_err = c_rs != RS_STOPPED;
                    c_ins = !susp_reg[s_tid];
                    c_rs  = RS_RUNNABLE;
                end
                OP_STOP: begin
                    c_err = c_rs == RS_STOPPED;
                    c_rem = 1'b1;
                    c_rs  = RS_STOPPED;
                end
                OP_WAIT: begin
                    c_err = c_rs != RS_RUNNABLE;
                    c_rem = 1'b1;
                    c_rs  = RS_WAITING;
                end
                OP_WAKE_UP: begin
                    c_err = c_rs != RS_WAITING;
                    c_ins = !susp_reg[s_tid];
                    c_rs  = RS_RUNNABLE;
                end
                OP_SUSPEND: begin
                    c_rem  = 1'b1;
                    c_susp = 1'b1;
                end
                OP_RESUME: begin
                    c_err  = !susp_reg[s_tid];
                    c_ins  = rs_reg[s_tid] == RS_RUNNABLE;
                    c_susp = 1'b0;
                end
                OP_YIELD: begin
                    // queued exactly when runnable and not suspended
                    c_rem = rs_reg[s_tid] == RS_RUNNABLE && !susp_reg[s_tid];
                    c_ins = c_rem;
                end
            endcase
        end
    end

    // sequencer
    logic [CW-1:0] pos_next;
    logic [CW-1:0] sh_next;
    logic          cnt_dec, cnt_inc, chg_set;
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        sh_next    = sh_reg;
        rd_en      = 1'b0;
        rd_addr    = pos_ix;
        wr_en      = 1'b0;
        wr_addr    = pos_ix;
        wr_data    = rd_data_reg;
        cnt_dec    = 1'b0;
        cnt_inc    = 1'b0;
        chg_set    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                pos_next = '0;
                rd_addr  = '0;
                if (accept) begin
                    if (c_err) begin
                        state_next = ST_HEAD;
                    end else if (c_rem) begin
                        state_next = ST_RFIND;
                        rd_en      = 1'b1;
                    end else if (c_ins) begin
                        state_next = ST_IFIND;
                        rd_en      = 1'b1;
                    end else begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_RFIND: begin
                // rd_data_reg holds entry pos_reg when pos_reg < count
                if (pos_reg >= count_reg) begin
                    // not in queue: go on to insert or finish
                    pos_next   = '0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = do_ins_reg ? ST_IFIND : ST_HEAD;
                end else begin
                    pos_next = pos_reg + 1'b1;
                    rd_en    = (pos_reg + 1'b1) < count_reg;
                    rd_addr  = IW'(pos_reg + 1'b1);
                    if (rd_data_reg == tid_reg) begin
                        chg_set    = (pos_reg == '0);
                        state_next = ST_RSHIFT;
                    end
                end
            end
            ST_RSHIFT: begin
                // rd_data_reg holds entry pos_reg; move it down one
                if (pos_reg >= count_reg) begin
                    cnt_dec    = 1'b1;
                    pos_next   = '0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = do_ins_reg ? ST_IFIND : ST_HEAD;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = IW'(pos_reg - 1'b1);
                    wr_data  = rd_data_reg;
                    pos_next = pos_reg + 1'b1;
                    rd_en    = (pos_reg + 1'b1) < count_reg;
                    rd_addr  = IW'(pos_reg + 1'b1);
                end
            end
            ST_IFIND: begin
                // stop at the first entry of lower priority
                if (pos_reg >= count_reg) begin
                    state_next = ST_ISET;
                end else if (prio_reg[rd_data_reg] < prio_reg[tid_reg]) begin
                    sh_next    = count_reg;
                    rd_en      = 1'b1;
                    rd_addr    = IW'(count_reg - 1'b1);
                    state_next = ST_ISHIFT;
                end else begin
                    pos_next = pos_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = IW'(pos_reg + 1'b1);
                end
            end
            ST_ISHIFT: begin
                // rd_data_reg holds entry sh_reg-1, write to sh_reg
                wr_en   = 1'b1;
                wr_addr = IW'(sh_reg);
                wr_data = rd_data_reg;
                if ((sh_reg - 1'b1) == pos_reg) begin
                    state_next = ST_ISET;
                end else begin
                    sh_next = sh_reg - 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = IW'(sh_reg - CW'(2));
                end
            end
            ST_ISET: begin
                wr_en      = 1'b1;
                wr_addr    = pos_ix;
                wr_data    = tid_reg;
                cnt_inc    = 1'b1;
                chg_set    = (pos_reg == '0);
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // wait here while the previous result is still held
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_THREADS; i++) begin
                prio_reg[i] <= '0;
                rs_reg[i]   <= RS_STOPPED;
                susp_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            sh_reg    <= sh_next;
            if (cnt_dec) begin
                count_reg <= count_reg - 1'b1;
            end else if (cnt_inc) begin
                count_reg <= count_reg + 1'b1;
            end
            if (accept) begin
                chg_reg <= 1'b0;
            end else if (chg_set) begin
                chg_reg <= 1'b1;
            end
            if (accept) begin
                tid_reg    <= s_tid;
                err_reg    <= c_err;
                do_ins_reg <= c_ins;
                if (!c_err) begin
                    rs_reg[s_tid]   <= c_rs;
                    susp_reg[s_tid] <= c_susp;
                    if (s_opcode == OP_CREATE) begin
                        prio_reg[s_tid] <= PRIORITY_BITS'(s_create_prio);
                    end
                end
            end
            if (state_reg == ST_DONE && out_free) begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= err_reg;
                out_hv_reg     <= count_reg != '0;
                out_head_reg   <= (count_reg != '0) ? rd_data_reg : '0;
                out_chg_reg    <= !err_reg && chg_reg;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // a held result stays put until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_status, m_head_valid,
            m_head_thread, m_schedule_changed}))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_THREADS))
        else $error("ready count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_schedule_changed)
        else $error("error result reports a schedule change");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_head_valid || m_head_thread == '0))
        else $error("head thread set on empty queue");

endmodule : priority_ready_queue_thread_states
`default_nettype wire
